/* src/swkr_pkg.sv */
// shared types and codes for the keyed-remove stack
// used by swkr_cell, the core and its checker; no dependencies
`default_nettype none

package swkr_pkg;

    localparam int KEY_W    = 32;
    localparam int CAP_W    = 5;
    localparam int CNT_OUT_W = 5;

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0]     value;
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty_res;
    } t_res;

    // cell moves: hold, toward the bottom end (push), toward the top (pop),
    // or close the gap left by the topmost match (remove)
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_UP,
        SH_DOWN,
        SH_REMOVE
    } t_shift;

    typedef struct packed {
        t_shift shift;
        logic   remove_go;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* src/swkr_cell.sv */
// one stack cell: holds a word, compares it to the key, moves with its neighbors
// depends on swkr_pkg
`default_nettype none

module swkr_cell
    import swkr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [KEY_W-1:0] i_prev,
    input  wire logic [KEY_W-1:0] i_next,
    input  wire logic             i_valid,
    input  wire logic             i_hit,
    output logic                  o_hit,
    output logic [KEY_W-1:0]      o_data
);

    logic [KEY_W-1:0] r_data;
    logic [KEY_W-1:0] n_data;
    logic             match;

    assign match  = i_valid && (r_data == i_key);
    // hit ripples away from the top of stack, so a cell sees matches nearer the top
    assign o_hit  = i_hit | match;
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.shift)
            SH_HOLD:   n_data = r_data;
            SH_UP:     n_data = i_prev;
            SH_DOWN:   n_data = i_next;
            SH_REMOVE: begin
                // the topmost match and every cell below it take the one nearer the bottom
                if (i_ctl.remove_go && (i_hit || match)) begin
                    n_data = i_next;
                end
            end
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

/* src/stack_with_keyed_remove_core.sv */
// channel  | ports                          | moves
// request  | start, busy, i_req             | mode and key, taken when start && !busy
// result   | o_done, o_res                  | value, status, count, empty flag, one cycle
// config   | i_cfg_valid, o_cfg_ready, i_cfg_data | capacity word
//
// one request per cycle while busy is low: the cell row updates at the accepting edge and
// the result is shown on the next cycle, so throughput is one word per clock.
// the longest path is the match ripple through all DEPTH cells for remove.
// reset clears the count, sets capacity to 16 and sets busy, which clears once reset is released.
// the receiver cannot stall; config is always ready.
// depends on swkr_pkg and swkr_cell
`default_nettype none

module stack_with_keyed_remove_core
    import swkr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    output logic                  o_done,
    output t_res                  o_res,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CAP_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CAP_W-1:0] r_cap;
    logic             r_busy;
    logic             r_done;
    t_res             r_res;
    t_res             n_res;

    logic             accept;
    logic             full;
    logic             any_match;
    logic [XW-1:0]    count_x;
    t_cell_ctl        ctl;

    logic [KEY_W-1:0] cell_data [DEPTH];
    logic [DEPTH:0]   hit;
    logic [KEY_W-1:0] top_in;

    assign accept      = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_res       = r_res;

    assign full = (XW'(r_count) >= XW'(r_cap)) || (r_count >= CW'(DEPTH));
    assign any_match = hit[DEPTH];
    // top of stack is cell 0; a push feeds the key in there
    assign top_in = (i_req.mode == MODE_PUSH) ? i_req.key : '0;
    assign hit[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_W-1:0] prev_w;
            logic [KEY_W-1:0] next_w;
            if (g == 0) begin : g_first
                assign prev_w = top_in;
            end else begin : g_mid
                assign prev_w = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign next_w = '0;
            end else begin : g_inner
                assign next_w = cell_data[g+1];
            end
            swkr_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_key   (i_req.key),
                .i_prev  (prev_w),
                .i_next  (next_w),
                .i_valid (r_count > CW'(g)),
                .i_hit   (hit[g]),
                .o_hit   (hit[g+1]),
                .o_data  (cell_data[g])
            );
        end
    endgenerate

    always_comb begin
        ctl.shift     = SH_HOLD;
        ctl.remove_go = any_match;
        n_count       = r_count;
        n_res.value   = '0;
        n_res.status  = ST_OK;
        if (accept) begin
            unique case (i_req.mode)
                MODE_PUSH: begin
                    if (full) begin
                        n_res.status = ST_OVERFLOW;
                    end else begin
                        ctl.shift = SH_UP;
                        n_count   = r_count + CW'(1);
                    end
                end
                MODE_POP: begin
                    if (r_count == '0) begin
                        n_res.status = ST_UNDERFLOW;
                    end else begin
                        ctl.shift   = SH_DOWN;
                        n_count     = r_count - CW'(1);
                        n_res.value = cell_data[0];
                    end
                end
                MODE_REMOVE: begin
                    if (any_match) begin
                        ctl.shift = SH_REMOVE;
                        n_count   = r_count - CW'(1);
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    ctl.shift = SH_HOLD;
                end
            endcase
        end
        count_x         = XW'(n_count);
        n_res.count     = count_x[CNT_OUT_W-1:0];
        n_res.empty_res = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= 1'b0;
            r_done  <= accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
        r_res <= n_res;
    end

endmodule

`default_nettype wire

/* src/swkr_chk.sv */
// port-level checks for stack_with_keyed_remove_core, attached by bind
// depends on swkr_pkg
`default_nettype none

module swkr_chk
    import swkr_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire t_req i_req,
    input wire logic o_done,
    input wire t_res o_res
);

    // exactly one result word per accepted request, in the cycle after it is accepted
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted request gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without a request");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.empty_res) |-> (o_res.count == '0))
        else $error("empty flag with nonzero count");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_UNDERFLOW) |->
            (o_res.empty_res && o_res.value == '0 && $past(i_req.mode) == MODE_POP))
        else $error("bad underflow result");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_OVERFLOW) |->
            ($past(i_req.mode) == MODE_PUSH))
        else $error("overflow on a request that is not a push");

endmodule

bind stack_with_keyed_remove_core swkr_chk u_swkr_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_res   (o_res)
);

`default_nettype wire
